### design/lshbf_pkg.sv
// Shared opcodes, register indexes and sizing constants of the LSH Bloom filter block.
package lshbf_pkg;

  // Sizing is fixed: the word fields on the ports are cut for these values.
  localparam int TABLES = 8;
  localparam int FUNCS = 4;
  localparam int DIM = 32;
  localparam int BITS_PER_TABLE = 4096;

  typedef enum logic [2:0] {
    OP_LOAD_COEFF = 3'd0,
    OP_LOAD_OFFSET = 3'd1,
    OP_LOAD_MULT = 3'd2,
    OP_CLEAR = 3'd3,
    OP_INSERT = 3'd4,
    OP_QUERY = 3'd5,
    OP_RSVD6 = 3'd6,
    OP_RSVD7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    REG_INV_RADIUS = 2'd0,
    REG_INV_WIDTH = 2'd1,
    REG_PRIME = 2'd2,
    REG_TABLE_SIZE = 2'd3
  } reg_e;

  localparam logic [31:0] INV_RADIUS_RST = 32'd65536;
  localparam logic [31:0] INV_WIDTH_RST = 32'd16384;
  localparam logic [31:0] PRIME_RST = 32'd4294967291;
  localparam logic [12:0] TABLE_SIZE_RST = 13'd4096;

endpackage

### design/lsh_bloom_insert_query_top.sv
// LSH Bloom filter insert/query engine: loads, vector buffer, hash sequencer.
// Load and non-last element words leave the engine idle, ready for the next word.
// A last element starts the hash: per table, the shared MAC loop over DIM
// elements per function, the iterative remainder unit (by the prime, then by the
// table size; size only when the prime is zero), the filter read-modify-write and
// the result handoff. Reset and a clear word run a clearing pass over all
// TABLES*BITS_PER_TABLE (32768 by default) filter bits; no word is taken meanwhile.
module lsh_bloom_insert_query_top
  import lshbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  table_sel_i,
  input  logic [1:0]  func_sel_i,
  input  logic [4:0]  elem_index_i,
  input  logic signed [31:0] value_i,
  input  logic [29:0] multiplier_i,
  input  logic        last_element_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  table_out_o,
  output logic [11:0] bucket_o,
  output logic        already_set_o,
  output logic        last_result_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int TF = TABLES * FUNCS;
  localparam int CDEPTH = TF * DIM;
  localparam int FDEPTH = TABLES * BITS_PER_TABLE;
  localparam int T_W = TABLES > 1 ? $clog2(TABLES) : 1;
  localparam int F_W = FUNCS > 1 ? $clog2(FUNCS) : 1;
  localparam int K_W = DIM > 1 ? $clog2(DIM) : 1;
  localparam int CA_W = CDEPTH > 1 ? $clog2(CDEPTH) : 1;
  localparam int OA_W = TF > 1 ? $clog2(TF) : 1;
  localparam int FA_W = FDEPTH > 1 ? $clog2(FDEPTH) : 1;
  localparam int B_W = $clog2(BITS_PER_TABLE);
  localparam int ACC_W = 49 + K_W;
  localparam logic [31:0] BPT_W = 32'(BITS_PER_TABLE);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MUL, S_ACC, S_SAT, S_OFF, S_SHF, S_HACC,
    S_DIV, S_FRD, S_FWR, S_WAIT
  } state_e;

  state_e state_q;

  logic [31:0] inv_radius_q, inv_width_q, prime_q;
  logic [12:0] table_size_q;

  logic [T_W-1:0] t_q;
  logic [F_W-1:0] f_q;
  logic [K_W-1:0] k_q;
  logic           insert_q;
  logic [FA_W-1:0] clr_q;

  logic signed [63:0] mac_p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [64:0] prod_q;
  logic [31:0] hm_q, gacc_q;
  logic [31:0] rem_q, num_q, div_q;
  logic [4:0]  dcnt_q;
  logic        dpass_q;
  logic [B_W-1:0] bkt_q;

  logic        out_valid_q, was_q;
  logic [2:0]  table_out_q;
  logic [11:0] bucket_out_q;
  logic        last_q;

  // RAM ports
  logic            c_we, v_we, o_we, m_we, f_we;
  logic [CA_W-1:0] c_waddr, c_raddr;
  logic [K_W-1:0]  v_waddr;
  logic [OA_W-1:0] o_waddr, o_raddr;
  logic [FA_W-1:0] f_waddr, f_raddr;
  logic            f_wdata;
  logic [31:0]     c_rdata, v_rdata, o_rdata;
  logic [29:0]     m_rdata;
  logic [0:0]      f_rdata;

  logic in_acc, sel_ok, elem_ok;
  logic [31:0] c_wfull, c_rfull, o_wfull, o_rfull, f_rfull;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign sel_ok = (32'(table_sel_i) < 32'(TABLES)) && (32'(func_sel_i) < 32'(FUNCS));
  assign elem_ok = 32'(elem_index_i) < 32'(DIM);

  // load addresses from the word, hash addresses from the sequencer
  assign o_wfull = 32'(table_sel_i) * 32'(FUNCS) + 32'(func_sel_i);
  assign c_wfull = o_wfull * 32'(DIM) + 32'(elem_index_i);
  assign o_rfull = 32'(t_q) * 32'(FUNCS) + 32'(f_q);
  assign c_rfull = o_rfull * 32'(DIM) + 32'(k_q);
  assign f_rfull = 32'(t_q) * BPT_W + 32'(bkt_q);

  assign c_waddr = CA_W'(c_wfull);
  assign o_waddr = OA_W'(o_wfull);
  assign v_waddr = K_W'(elem_index_i);
  assign c_raddr = CA_W'(c_rfull);
  assign o_raddr = OA_W'(o_rfull);
  assign f_raddr = FA_W'(f_rfull);

  assign c_we = in_acc && opcode_i == OP_LOAD_COEFF && sel_ok && elem_ok;
  assign o_we = in_acc && opcode_i == OP_LOAD_OFFSET && sel_ok;
  assign m_we = in_acc && opcode_i == OP_LOAD_MULT && sel_ok;
  assign v_we = in_acc && (opcode_i == OP_INSERT || opcode_i == OP_QUERY) && elem_ok;

  // filter write: zero during the clearing pass, one on every insert
  always_comb begin
    f_we = 1'b0;
    f_waddr = f_raddr;
    f_wdata = 1'b1;
    if (state_q == S_CLEAR) begin
      f_we = 1'b1;
      f_waddr = clr_q;
      f_wdata = 1'b0;
    end else if (state_q == S_FWR && insert_q) begin
      f_we = 1'b1;
    end
  end

  lshbf_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coeff (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(value_i),
    .raddr_i(c_raddr), .rdata_o(c_rdata));
  lshbf_ram #(.WIDTH(32), .DEPTH(DIM)) u_vec (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(value_i),
    .raddr_i(k_q), .rdata_o(v_rdata));
  lshbf_ram #(.WIDTH(32), .DEPTH(TF)) u_offset (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(value_i),
    .raddr_i(o_raddr), .rdata_o(o_rdata));
  lshbf_ram #(.WIDTH(30), .DEPTH(TF)) u_mult (
    .clk_i, .we_i(m_we), .waddr_i(o_waddr), .wdata_i(multiplier_i),
    .raddr_i(o_raddr), .rdata_o(m_rdata));
  lshbf_ram #(.WIDTH(1), .DEPTH(FDEPTH)) u_filter (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata));

  // datapath helpers
  logic signed [63:0] mac_p;
  logic signed [31:0] dot_sat, y_sat;
  logic signed [49:0] y_pre;
  logic signed [63:0] z_sh;
  logic [6:0]  tt;
  logic [32:0] trial;
  logic [31:0] rem_nx;
  logic [31:0] size_eff;

  assign mac_p = $signed(v_rdata) * $signed(c_rdata);

  // saturate the dot sum to signed 32 bits
  always_comb begin
    if ((&acc_q[ACC_W-1:31]) || !(|acc_q[ACC_W-1:31])) begin
      dot_sat = acc_q[31:0];
    end else begin
      dot_sat = acc_q[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // floor to Q16.16, add offset, saturate
  always_comb begin
    y_pre = 50'(prod_q >>> 16) + 50'($signed(o_rdata));
    if ((&y_pre[49:31]) || !(|y_pre[49:31])) begin
      y_sat = y_pre[31:0];
    end else begin
      y_sat = y_pre[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // scale by 2^t and drop 32 fraction bits
  always_comb begin
    tt = 7'(t_q);
    if (tt < 7'd32) begin
      z_sh = prod_q[63:0] >>> (7'd32 - tt);
    end else begin
      z_sh = prod_q[63:0] << (tt - 7'd32);
    end
  end

  // one restoring remainder step
  assign trial = {rem_q, num_q[31]};
  assign rem_nx = (trial >= {1'b0, div_q}) ? 32'(trial - {1'b0, div_q}) : trial[31:0];

  always_comb begin
    if (table_size_q == 13'd0) begin
      size_eff = 32'd1;
    end else if (32'(table_size_q) > BPT_W) begin
      size_eff = BPT_W;
    end else begin
      size_eff = 32'(table_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      inv_radius_q <= INV_RADIUS_RST;
      inv_width_q <= INV_WIDTH_RST;
      prime_q <= PRIME_RST;
      table_size_q <= TABLE_SIZE_RST;
      t_q <= '0;
      f_q <= '0;
      k_q <= '0;
      insert_q <= 1'b0;
      dcnt_q <= '0;
      dpass_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_e'(cfg_index_i))
          REG_INV_RADIUS: inv_radius_q <= cfg_data_i;
          REG_INV_WIDTH: inv_width_q <= cfg_data_i;
          REG_PRIME: prime_q <= cfg_data_i;
          REG_TABLE_SIZE: table_size_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == FA_W'(FDEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (opcode_i) inside
              OP_CLEAR: begin
                clr_q <= '0;
                state_q <= S_CLEAR;
              end
              OP_INSERT, OP_QUERY: begin
                if (last_element_i) begin
                  insert_q <= (opcode_i == OP_INSERT);
                  t_q <= '0;
                  f_q <= '0;
                  k_q <= '0;
                  acc_q <= '0;
                  gacc_q <= '0;
                  state_q <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          mac_p_q <= mac_p;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_q + ACC_W'(mac_p_q >>> 16);
          if (k_q == K_W'(DIM - 1)) begin
            state_q <= S_SAT;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_SAT: begin
          prod_q <= dot_sat * $signed({1'b0, inv_radius_q});
          state_q <= S_OFF;
        end
        S_OFF: begin
          prod_q <= y_sat * $signed({1'b0, inv_width_q});
          state_q <= S_SHF;
        end
        S_SHF: begin
          hm_q <= 32'(z_sh[31:0] * m_rdata);
          state_q <= S_HACC;
        end
        S_HACC: begin
          k_q <= '0;
          acc_q <= '0;
          if (f_q == F_W'(FUNCS - 1)) begin
            // reduce by the prime, or skip to the size pass when it is zero
            if (prime_q != 32'd0) begin
              num_q <= gacc_q + hm_q;
              div_q <= prime_q;
              dpass_q <= 1'b0;
            end else begin
              num_q <= gacc_q + hm_q;
              div_q <= size_eff;
              dpass_q <= 1'b1;
            end
            rem_q <= '0;
            dcnt_q <= '0;
            state_q <= S_DIV;
          end else begin
            gacc_q <= gacc_q + hm_q;
            f_q <= f_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'd31) begin
            if (!dpass_q) begin
              // restart on the prime remainder with the table size
              num_q <= rem_nx;
              rem_q <= '0;
              div_q <= size_eff;
              dpass_q <= 1'b1;
            end else begin
              bkt_q <= B_W'(rem_nx);
              state_q <= S_FRD;
            end
          end else begin
            num_q <= {num_q[30:0], 1'b0};
            rem_q <= rem_nx;
          end
        end
        S_FRD: begin
          state_q <= S_FWR;
        end
        S_FWR: begin
          // present the result; the filter bit is set in this cycle on insert
          out_valid_q <= 1'b1;
          was_q <= f_rdata[0];
          table_out_q <= 3'(t_q);
          bucket_out_q <= 12'(bkt_q);
          last_q <= (t_q == T_W'(TABLES - 1));
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (t_q == T_W'(TABLES - 1)) begin
              state_q <= S_IDLE;
            end else begin
              t_q <= t_q + 1'b1;
              f_q <= '0;
              k_q <= '0;
              acc_q <= '0;
              gacc_q <= '0;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign table_out_o = table_out_q;
  assign bucket_o = bucket_out_q;
  assign already_set_o = was_q;
  assign last_result_o = last_q;

endmodule

### design/lshbf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lshbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### dv/lsh_bloom_insert_query_top_tb.sv
// Self-checking testbench for the LSH Bloom filter insert/query engine.
module lsh_bloom_insert_query_top_tb;
  import lshbf_pkg::*;

  localparam int NTAB = 8;
  localparam int NFUNC = 4;
  localparam int NDIM = 32;
  localparam int NBITS = 4096;
  localparam int CYCLE_LIMIT = 30000000;
  localparam int SETTLE_CYCLES = 400;

  // One input word as presented on the input channel. A pinned row carries
  // a typed-in value for already_set that replaces the computed one.
  typedef struct {
    op_e         op;
    logic [2:0]  tsel;
    logic [1:0]  fsel;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [29:0] mult;
    logic        last;
    logic        pin;
    logic        pin_set;
  } word_t;

  typedef struct {
    logic [2:0]  tbl;
    logic [11:0] bucket;
    logic        hit;
    logic        last;
  } bucket_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  opcode_i;
  logic [2:0]  table_sel_i;
  logic [1:0]  func_sel_i;
  logic [4:0]  elem_index_i;
  logic signed [31:0] value_i;
  logic [29:0] multiplier_i;
  logic        last_element_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  table_out_o;
  logic [11:0] bucket_o;
  logic        already_set_o;
  logic        last_result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  lsh_bloom_insert_query_top dut (.*);

  // Shadow state of the filter, kept in step with accepted words.
  logic [31:0] sh_radius, sh_width, sh_prime;
  logic [12:0] sh_size;
  logic [31:0] sh_coeff [NTAB*NFUNC*NDIM];
  logic [31:0] sh_offset [NTAB*NFUNC];
  logic [29:0] sh_mult [NTAB*NFUNC];
  logic [31:0] sh_vec [NDIM];
  logic        sh_bits [NTAB][NBITS];

  bucket_res_t pending_buckets [$];
  int          errs = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lsh_bloom_insert_query_top regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle away from the sampling edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < rx_idle_pct);
  end

  // Compare each accepted result word with the oldest predicted bucket.
  always @(posedge clk_i) begin
    bucket_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_buckets.size() == 0) begin
        $error("unexpected result word: table_out %0d bucket %0d", table_out_o, bucket_o);
        errs++;
      end else begin
        e = pending_buckets.pop_front();
        if (table_out_o !== e.tbl) begin
          $error("table_out exp %0d got %0d", e.tbl, table_out_o);
          errs++;
        end
        if (bucket_o !== e.bucket) begin
          $error("bucket exp %0d got %0d", e.bucket, bucket_o);
          errs++;
        end
        if (already_set_o !== e.hit) begin
          $error("already_set exp %0d got %0d", e.hit, already_set_o);
          errs++;
        end
        if (last_result_o !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, last_result_o);
          errs++;
        end
      end
    end
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Projection hash of one function: dot product, radius scale, offset,
  // bucket-width scale, then the table's power-of-two stretch.
  function automatic logic [31:0] proj_hash(int t, int f);
    int     base;
    longint dot, y, z;
    base = (t * NFUNC + f) * NDIM;
    dot = 0;
    for (int k = 0; k < NDIM; k++)
      dot += (longint'($signed(sh_vec[k])) * longint'($signed(sh_coeff[base + k]))) >>> 16;
    dot = clamp32(dot);
    y = (dot * longint'({32'd0, sh_radius})) >>> 16;
    y = clamp32(y + longint'($signed(sh_offset[t * NFUNC + f])));
    z = y * longint'({32'd0, sh_width});
    return 32'(z >>> (32 - t));
  endfunction

  function automatic logic [11:0] table_bucket(int t);
    logic [31:0] acc;
    logic [31:0] size;
    acc = '0;
    for (int f = 0; f < NFUNC; f++)
      acc = 32'(longint'({32'd0, acc})
                + longint'({32'd0, proj_hash(t, f)}) * longint'({34'd0, sh_mult[t * NFUNC + f]}));
    if (sh_prime != 0) acc = acc % sh_prime;
    size = {19'd0, sh_size};
    if (size == 0) size = 1;
    if (size > NBITS) size = NBITS;
    return 12'(acc % size);
  endfunction

  // Update shadow state for an accepted word and queue its results.
  task automatic apply_word(word_t w);
    int          sel;
    bucket_res_t r;
    sel = w.tsel * NFUNC + w.fsel;
    case (w.op)
      OP_LOAD_COEFF:  sh_coeff[sel * NDIM + w.idx] = w.val;
      OP_LOAD_OFFSET: sh_offset[sel] = w.val;
      OP_LOAD_MULT:   sh_mult[sel] = w.mult;
      OP_CLEAR: begin
        for (int t = 0; t < NTAB; t++)
          for (int b = 0; b < NBITS; b++) sh_bits[t][b] = 1'b0;
      end
      OP_INSERT, OP_QUERY: begin
        sh_vec[w.idx] = w.val;
        if (w.last) begin
          for (int t = 0; t < NTAB; t++) begin
            r.tbl = 3'(t);
            r.bucket = table_bucket(t);
            r.hit = w.pin ? w.pin_set : sh_bits[t][r.bucket];
            r.last = (t == NTAB - 1);
            if (w.op == OP_INSERT) sh_bits[t][r.bucket] = 1'b1;
            pending_buckets.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one word, hold it through stalls, and predict once it is taken.
  task automatic send_word(word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i = w.op;
    table_sel_i = w.tsel;
    func_sel_i = w.fsel;
    elem_index_i = w.idx;
    value_i = w.val;
    multiplier_i = w.mult;
    last_element_i = w.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(w);
    @(negedge clk_i);
  endtask

  function automatic word_t mk(op_e op, int tsel, int fsel, int idx, logic [31:0] val,
                               logic [29:0] mult, logic last);
    word_t w;
    w.op = op;
    w.tsel = 3'(tsel);
    w.fsel = 2'(fsel);
    w.idx = 5'(idx);
    w.val = val;
    w.mult = mult;
    w.last = last;
    w.pin = 1'b0;
    w.pin_set = 1'b0;
    return w;
  endfunction

  function automatic word_t pinned(word_t w, logic hit);
    w.pin = 1'b1;
    w.pin_set = hit;
    return w;
  endfunction

  function automatic logic [31:0] rand_val();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    // small magnitudes keep the hash out of saturation most of the time
    if (r < 65) return 32'($signed($urandom_range(524288)) - 262144);
    return $urandom;
  endfunction

  function automatic logic [29:0] rand_mult();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 30'h2000_0000;
    if (r == 1) return 30'($urandom);
    return 30'($urandom_range(32'h2000_0000));
  endfunction

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INV_RADIUS: sh_radius = data;
      REG_INV_WIDTH:  sh_width = data;
      REG_PRIME:      sh_prime = data;
      REG_TABLE_SIZE: sh_size = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold until every predicted bucket has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_buckets.size() != 0) @(negedge clk_i);
  endtask

  // Random traffic: mostly whole vectors, with reloads, clears and noise.
  task automatic random_words(int count, inout int clears_left);
    int    n;
    int    r;
    int    len;
    op_e   op;
    word_t w;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_word(mk(OP_LOAD_COEFF, $urandom_range(7), $urandom_range(3),
                     $urandom_range(31), rand_val(), rand_mult(), 1'($urandom)));
        n++;
      end else if (r < 11) begin
        send_word(mk(OP_LOAD_OFFSET, $urandom_range(7), $urandom_range(3),
                     $urandom_range(31), rand_val(), rand_mult(), 1'($urandom)));
        n++;
      end else if (r < 14) begin
        send_word(mk(OP_LOAD_MULT, $urandom_range(7), $urandom_range(3),
                     $urandom_range(31), rand_val(), rand_mult(), 1'($urandom)));
        n++;
      end else if (r < 17) begin
        // reserved opcodes are dropped and not counted
        send_word(mk($urandom_range(1) ? OP_RSVD6 : OP_RSVD7, $urandom_range(7),
                     $urandom_range(3), $urandom_range(31), $urandom, rand_mult(),
                     1'($urandom)));
      end else if (r < 18 && clears_left > 0) begin
        send_word(mk(OP_CLEAR, $urandom_range(7), $urandom_range(3), $urandom_range(31),
                     $urandom, rand_mult(), 1'($urandom)));
        clears_left--;
        n++;
      end else if (r < 40) begin
        // rewrite one element with its current value: the vector stays unchanged
        op = $urandom_range(1) ? OP_INSERT : OP_QUERY;
        len = $urandom_range(31);
        send_word(mk(op, $urandom_range(7), $urandom_range(3), len, sh_vec[len],
                     rand_mult(), 1'b1));
        n++;
      end else begin
        op = ($urandom_range(9) < 6) ? OP_INSERT : OP_QUERY;
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) begin
          w = mk(op, $urandom_range(7), $urandom_range(3), $urandom_range(31), rand_val(),
                 rand_mult(), i == len - 1);
          send_word(w);
          n++;
        end
      end
    end
  endtask

  word_t       directed [$];
  logic [31:0] settings [5][4];
  int          clears_left;

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    opcode_i = OP_QUERY;
    table_sel_i = '0;
    func_sel_i = '0;
    elem_index_i = '0;
    value_i = '0;
    multiplier_i = '0;
    last_element_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_INV_RADIUS;
    cfg_data_i = '0;
    sh_radius = INV_RADIUS_RST;
    sh_width = INV_WIDTH_RST;
    sh_prime = PRIME_RST;
    sh_size = TABLE_SIZE_RST;
    for (int t = 0; t < NTAB; t++)
      for (int b = 0; b < NBITS; b++) sh_bits[t][b] = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill every coefficient, offset, multiplier and vector element first, so
    // no hash ever reads an entry that was never written.
    for (int t = 0; t < NTAB; t++)
      for (int f = 0; f < NFUNC; f++) begin
        for (int k = 0; k < NDIM; k++)
          send_word(mk(OP_LOAD_COEFF, t, f, k, rand_val(), '0, 1'b0));
        send_word(mk(OP_LOAD_OFFSET, t, f, 0, rand_val(), '0, 1'b0));
        send_word(mk(OP_LOAD_MULT, t, f, 0, '0, rand_mult(), 1'b0));
      end
    for (int k = 0; k < NDIM; k++)
      send_word(mk(OP_INSERT, 0, 0, k, rand_val(), '0, 1'b0));

    tx_idle_pct = 17;
    rx_idle_pct = 69;

    // Directed words: repeated vector hits, clear, extremes, ignored opcodes.
    directed.push_back(mk(OP_INSERT, 0, 0, 0, 32'h0, '0, 1'b1));
    directed.push_back(pinned(mk(OP_INSERT, 0, 0, 0, 32'h0, '0, 1'b1), 1'b1));
    directed.push_back(pinned(mk(OP_QUERY, 0, 0, 0, 32'h0, '0, 1'b1), 1'b1));
    directed.push_back(mk(OP_CLEAR, 7, 3, 31, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1));
    directed.push_back(pinned(mk(OP_QUERY, 0, 0, 0, 32'h0, '0, 1'b1), 1'b0));
    directed.push_back(mk(OP_INSERT, 0, 0, 5, 32'h7FFF_FFFF, '0, 1'b1));
    directed.push_back(mk(OP_INSERT, 0, 0, 31, 32'h8000_0000, '0, 1'b1));
    directed.push_back(mk(OP_LOAD_COEFF, 7, 3, 31, 32'h8000_0000, '0, 1'b0));
    directed.push_back(mk(OP_LOAD_COEFF, 0, 0, 0, 32'h7FFF_FFFF, '0, 1'b0));
    directed.push_back(mk(OP_LOAD_OFFSET, 0, 0, 0, 32'h7FFF_FFFF, '0, 1'b0));
    directed.push_back(mk(OP_LOAD_OFFSET, 7, 3, 0, 32'h8000_0000, '0, 1'b0));
    directed.push_back(mk(OP_LOAD_MULT, 7, 3, 0, '0, 30'h2000_0000, 1'b0));
    directed.push_back(mk(OP_LOAD_MULT, 0, 0, 0, '0, 30'h0, 1'b0));
    directed.push_back(mk(OP_QUERY, 0, 0, 3, 32'hFFFF_FFFF, '0, 1'b0));
    directed.push_back(mk(OP_RSVD6, 1, 1, 3, 32'h1234_5678, 30'h155, 1'b1));
    directed.push_back(mk(OP_RSVD7, 2, 2, 4, 32'h8765_4321, 30'h2AA, 1'b1));
    directed.push_back(mk(OP_QUERY, 0, 0, 3, 32'hFFFF_FFFF, '0, 1'b1));
    directed.push_back(mk(OP_INSERT, 0, 0, 3, 32'hFFFF_FFFF, '0, 1'b1));
    directed.push_back(pinned(mk(OP_QUERY, 0, 0, 3, 32'hFFFF_FFFF, '0, 1'b1), 1'b1));
    foreach (directed[i]) send_word(directed[i]);

    // Register settings per phase, extremes included; last one is reset values.
    settings[0] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
    settings[1] = '{32'hFFFF_FFFF, 32'h0, 32'd2, 32'd1};
    settings[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FFF};
    settings[3] = '{32'h0001_8000, 32'h0001_0000, 32'd4093, 32'd1000};
    settings[4] = '{INV_RADIUS_RST, INV_WIDTH_RST, PRIME_RST, 32'(TABLE_SIZE_RST)};

    clears_left = 2;
    for (int p = 0; p < 5; p++) begin
      // quiesce: let every predicted bucket come back before touching registers
      drain();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      write_reg(REG_INV_RADIUS, settings[p][0]);
      write_reg(REG_INV_WIDTH, settings[p][1]);
      write_reg(REG_PRIME, settings[p][2]);
      write_reg(REG_TABLE_SIZE, settings[p][3]);
      if (p == 2) begin
        tx_idle_pct = 69;
        rx_idle_pct = 17;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_words(30, clears_left);
      // sender holds off once until every pending bucket is back
      if (p == 1) drain();
      random_words(30, clears_left);
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errs == 0) begin
      $display("lsh_bloom_insert_query_top regression: pass");
    end else begin
      $display("lsh_bloom_insert_query_top regression: fail");
    end
    $finish;
  end

endmodule

### lsh_bloom_insert_query_top.f
design/lshbf_pkg.sv
design/lshbf_ram.sv
design/lsh_bloom_insert_query_top.sv
dv/lsh_bloom_insert_query_top_tb.sv
